### hw/rtl/kf1d_pkg.sv
package kf1d_pkg;

  // Field widths fixed by the data formats.
  localparam int DATA_W     = 32;  // angles, rates, variances
  localparam int STEP_W     = 24;  // step time, unsigned Q0.24
  localparam int FRAC_W     = 24;  // fraction bits of gain and step time
  localparam int QUO_W      = 25;  // gain, 0 .. 1.0 in unsigned Q1.24
  localparam int CFG_ADDR_W = 4;   // three 32-bit registers at 0, 4, 8

  // Rounding offset for a shift by FRAC_W.
  localparam int RND_HALF = 2 ** (FRAC_W - 1);

  // Reset values.
  localparam logic [STEP_W-1:0] STEP_TIME_RESET = 24'd67109;
  localparam logic [DATA_W-1:0] PROC_INC_RESET  = 32'd4295;
  localparam logic [DATA_W-1:0] MEAS_VAR_RESET  = 32'd150994944;
  localparam logic [DATA_W-1:0] VAR_RESET       = 32'd67108864;

  // Gain of exactly 1.0.
  localparam logic [QUO_W-1:0] GAIN_ONE = 25'd16777216;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STEP_TIME = 2'd0,
    REG_PROC_INC  = 2'd1,
    REG_MEAS_VAR  = 2'd2
  } reg_idx_t;

  typedef logic signed [DATA_W-1:0] angle_t;
  typedef logic [DATA_W-1:0]        var_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_time;
    var_t              process_increment;
    var_t              measurement_variance;
  } cfg_t;

  // Clamp a 36-bit signed value to the 32-bit signed range.
  function automatic angle_t sat_s36(input logic signed [35:0] x);
    logic signed [35:0] hi_lim;
    logic signed [35:0] lo_lim;
    hi_lim = 36'sh07FFFFFFF;
    lo_lim = -36'sh080000000;
    if (x > hi_lim) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo_lim) begin
      return 32'sh80000000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/kf1d_sample_if.sv
interface kf1d_sample_if;
  import kf1d_pkg::*;

  logic   valid;
  logic   ready;
  logic   channel;
  angle_t rate;
  angle_t measured_angle;

  modport source (output valid, output channel, output rate, output measured_angle,
                  input ready);
  modport sink (input valid, input channel, input rate, input measured_angle,
                output ready);
endinterface

### hw/rtl/kf1d_result_if.sv
interface kf1d_result_if;
  import kf1d_pkg::*;

  logic   valid;
  logic   ready;
  logic   out_channel;
  angle_t angle_estimate;
  var_t   uncertainty;

  modport source (output valid, output out_channel, output angle_estimate,
                  output uncertainty, input ready);
  modport sink (input valid, input out_channel, input angle_estimate,
                input uncertainty, output ready);
endinterface

### hw/rtl/kf1d_cfg_regs.sv
module kf1d_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kf1d_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output kf1d_pkg::cfg_t                  cfg
);
  import kf1d_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_time            <= STEP_TIME_RESET;
      cfg.process_increment    <= PROC_INC_RESET;
      cfg.measurement_variance <= MEAS_VAR_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_STEP_TIME: cfg.step_time            <= pwdata[STEP_W-1:0];
        REG_PROC_INC:  cfg.process_increment    <= pwdata;
        REG_MEAS_VAR:  cfg.measurement_variance <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (idx)
      REG_STEP_TIME: prdata = {{(32 - STEP_W){1'b0}}, cfg.step_time};
      REG_PROC_INC:  prdata = cfg.process_increment;
      REG_MEAS_VAR:  prdata = cfg.measurement_variance;
      default:       prdata = '0;
    endcase
  end

endmodule

### hw/rtl/kf1d_ser_mul.sv
module kf1d_ser_mul #(
  parameter int A_W = 33,
  parameter int B_W = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [A_W-1:0]       a,
  input  logic [B_W-1:0]              b,
  output logic                        busy,
  output logic signed [A_W+B_W-1:0]   product
);
  localparam int CNT_W = $clog2(B_W + 1);

  logic signed [A_W-1:0] a_q;
  logic [B_W-1:0]        b_sh;
  logic signed [A_W+1:0] hi;
  logic [B_W-1:0]        lo;
  logic [CNT_W-1:0]      cnt;
  logic signed [A_W+1:0] addend;
  logic signed [A_W+1:0] sum;

  // One multiplier bit per cycle, LSB first: add the multiplicand into the
  // upper half and shift the finished low bit into the lower shift register.
  assign addend  = b_sh[0] ? {{2{a_q[A_W-1]}}, a_q} : '0;
  assign sum     = hi + addend;
  assign product = {hi[A_W-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(B_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      b_sh <= b;
      hi   <= '0;
      lo   <= '0;
    end else if (busy) begin
      hi   <= sum >>> 1;
      lo   <= {sum[0], lo[B_W-1:1]};
      b_sh <= b_sh >> 1;
    end
  end

endmodule

### hw/rtl/kf1d_gain_div.sv
module kf1d_gain_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kf1d_pkg::DATA_W-1:0] num,
  input  logic [kf1d_pkg::DATA_W:0]   den,
  output logic                        busy,
  output logic [kf1d_pkg::QUO_W-1:0]  quo
);
  import kf1d_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DATA_W+1:0] rem;
  logic [DATA_W:0]   den_q;
  logic [CNT_W-1:0]  cnt;
  logic              ge;
  logic [DATA_W+1:0] diff;
  logic [DATA_W+1:0] rem_keep;

  // Restoring division, one quotient bit per cycle. The numerator never
  // exceeds the denominator, so the first bit is the integer bit of the gain.
  assign ge       = rem >= {1'b0, den_q};
  assign diff     = rem - {1'b0, den_q};
  assign rem_keep = ge ? diff : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {2'b00, num};
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= {rem_keep[DATA_W:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

### hw/rtl/kalman_1d_angle_filter.sv
// Scalar Kalman filter with per-channel state for NUM_CHANNELS channels,
// fusing a gyro rate with an accelerometer angle (signed Q16.16) into a
// filtered angle and its variance (unsigned Q8.24). One word is processed at
// a time: a word on a valid channel holds off the next word until the
// bit-serial units are through: the 24-bit rate multiply runs alongside the
// 25-step gain divider, then the two 25-bit correction multiplies run side
// by side. A word for a channel at or above NUM_CHANNELS leaves the state
// alone and returns zeros. The result register lets a new word be accepted
// while the previous result waits. Registers step_time,
// process_increment and measurement_variance sit at byte addresses 0, 4 and 8
// and may only be written while the filter is idle.
module kalman_1d_angle_filter #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  kf1d_sample_if.sink                     sample,
  kf1d_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kf1d_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import kf1d_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_DSTART = 8'b0000_0100,
    S_PRED   = 8'b0000_1000,
    S_FIN1   = 8'b0001_0000,
    S_CSTART = 8'b0010_0000,
    S_CORR   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  cfg_t   cfg;

  // Per-channel state.
  angle_t est_store [NUM_CHANNELS];
  var_t   var_store [NUM_CHANNELS];

  // Item registers.
  logic              ch_q;
  logic              ch_ok_q;
  angle_t            rate_q;
  angle_t            meas_q;
  angle_t            e0_q;
  var_t              p1_q;
  logic              den_zero_q;
  angle_t            est1_q;
  logic [QUO_W-1:0]  k_q;
  logic [CH_W-1:0]   idx;

  // Arithmetic nets.
  logic [DATA_W:0]              p1_sum;
  logic [DATA_W:0]              den;
  logic [QUO_W-1:0]             quo;
  logic                         div_busy;
  logic signed [55:0]           prod1;
  logic signed [57:0]           prod2;
  logic signed [57:0]           prod3;
  logic                         mul1_busy;
  logic                         mul2_busy;
  logic                         mul3_busy;
  logic [56:0]                  d_rnd;
  logic signed [32:0]           d_val;
  logic signed [35:0]           est1_sum;
  logic signed [32:0]           innov;
  logic [QUO_W-1:0]             one_minus_k;
  logic [58:0]                  c_rnd;
  logic signed [34:0]           corr;
  logic signed [35:0]           est2_sum;
  angle_t                       est2;
  logic [57:0]                  p_rnd;
  var_t                         p2;
  logic                         out_free;
  logic                         accept;

  kf1d_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign idx    = CH_W'(ch_q);
  assign accept = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE);
  assign out_free     = !result.valid || result.ready;

  // Predict: variance plus process increment, saturated at all ones.
  assign p1_sum = {1'b0, var_store[idx]} + {1'b0, cfg.process_increment};
  assign den    = {1'b0, p1_q} + {1'b0, cfg.measurement_variance};

  // Rate times step time, rounded to Q16.16, then added to the estimate.
  assign d_rnd    = {prod1[55], prod1} + 57'(RND_HALF);
  assign d_val    = $signed(d_rnd[56:FRAC_W]);
  assign est1_sum = {{4{e0_q[31]}}, e0_q} + {{3{d_val[32]}}, d_val};

  // Correction operands.
  assign innov       = {meas_q[31], meas_q} - {est1_q[31], est1_q};
  assign one_minus_k = GAIN_ONE - k_q;

  // Corrected estimate and variance.
  assign c_rnd    = {prod2[57], prod2} + 59'(RND_HALF);
  assign corr     = $signed(c_rnd[58:FRAC_W]);
  assign est2_sum = {{4{est1_q[31]}}, est1_q} + {corr[34], corr};
  assign est2     = sat_s36(est2_sum);
  assign p_rnd    = prod3 + 58'(RND_HALF);
  assign p2       = p_rnd[55:FRAC_W];

  kf1d_ser_mul #(.A_W(32), .B_W(STEP_W)) u_mul_pred (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_LOAD),
    .a       (rate_q),
    .b       (cfg.step_time),
    .busy    (mul1_busy),
    .product (prod1)
  );

  kf1d_gain_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSTART),
    .num   (p1_q),
    .den   (den),
    .busy  (div_busy),
    .quo   (quo)
  );

  kf1d_ser_mul #(.A_W(33), .B_W(QUO_W)) u_mul_corr (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_CSTART),
    .a       (innov),
    .b       (k_q),
    .busy    (mul2_busy),
    .product (prod2)
  );

  kf1d_ser_mul #(.A_W(33), .B_W(QUO_W)) u_mul_var (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_CSTART),
    .a       ({1'b0, p1_q}),
    .b       (one_minus_k),
    .busy    (mul3_busy),
    .product (prod3)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (int'(sample.channel) < NUM_CHANNELS) ? S_LOAD : S_DONE;
        end
      end
      S_LOAD:   state_next = S_DSTART;
      S_DSTART: state_next = S_PRED;
      S_PRED: begin
        if (!mul1_busy && !div_busy) begin
          state_next = S_FIN1;
        end
      end
      S_FIN1:   state_next = S_CSTART;
      S_CSTART: state_next = S_CORR;
      S_CORR: begin
        if (!mul2_busy && !mul3_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q    <= sample.channel;
      ch_ok_q <= int'(sample.channel) < NUM_CHANNELS;
      rate_q  <= sample.rate;
      meas_q  <= sample.measured_angle;
    end
    if (state == S_LOAD) begin
      e0_q <= est_store[idx];
      p1_q <= p1_sum[DATA_W] ? '1 : p1_sum[DATA_W-1:0];
    end
    if (state == S_DSTART) begin
      den_zero_q <= (den == '0);
    end
    if (state == S_FIN1) begin
      est1_q <= sat_s36(est1_sum);
      k_q    <= den_zero_q ? '0 : quo;
    end
  end

  // Channel state: written back when the result is handed over.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        est_store[i] <= '0;
        var_store[i] <= VAR_RESET;
      end
    end else if (state == S_DONE && out_free && ch_ok_q) begin
      est_store[idx] <= est2;
      var_store[idx] <= p2;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.out_channel    <= ch_q;
      result.angle_estimate <= ch_ok_q ? est2 : '0;
      result.uncertainty    <= ch_ok_q ? p2 : '0;
    end
  end

  // The gain never exceeds 1.0.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CSTART |-> k_q <= GAIN_ONE)
    else $error("gain above 1.0");

  // The serial units are quiet whenever the sequencer is idle.
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mul1_busy && !mul2_busy && !mul3_busy && !div_busy)
    else $error("serial unit busy while idle");

  // The correct step never raises the variance above the predicted one.
  a_var_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && ch_ok_q |-> p2 <= p1_q)
    else $error("corrected variance above predicted variance");

  // A new result appears only out of the final sequencer state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_DONE))
    else $error("result raised outside the final state");

endmodule
